/* rtl/flp_pkg.sv */
// Shared constants, types and coefficient table of the 32-tap low-pass FIR filter.
package flp_pkg;

   localparam int TAPS        = 32;
   localparam int COEF_COUNT  = 32;
   localparam int COEF_IDX_W  = $clog2(COEF_COUNT);
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 18;
   localparam int OUT_W       = 24;
   localparam int ROUND_SHIFT = 10;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int ACC_W       = PROD_W + $clog2(TAPS);
   localparam int SUM_W       = ACC_W + 1;
   localparam int RND_W       = SUM_W - ROUND_SHIFT;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [COEF_W-1:0]   coef_type;
   typedef logic [ACC_W-1:0]    acc_type;
   typedef logic [OUT_W-1:0]    out_type;

   typedef struct packed {
      logic advance;
      logic clear;
   } ctl_type;

   localparam coef_type COEF_TABLE [COEF_COUNT] = '{
      18'd918,   18'd1077,  18'd1476,  18'd2128,  18'd3031,  18'd4166,  18'd5500,  18'd6984,
      18'd8560,  18'd10160, 18'd11711, 18'd13141, 18'd14381, 18'd15369, 18'd16057, 18'd16410,
      18'd16410, 18'd16057, 18'd15369, 18'd14381, 18'd13141, 18'd11711, 18'd10160, 18'd8560,
      18'd6984,  18'd5500,  18'd4166,  18'd3031,  18'd2128,  18'd1476,  18'd1077,  18'd918
   };

   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (ROUND_SHIFT - 1);
   localparam out_type          OUT_MAX    = '1;

   function automatic coef_type tap_coef(input int j);
      logic [COEF_IDX_W-1:0] idx;
      idx = j[COEF_IDX_W-1:0];
      if (j >= 0 && j < COEF_COUNT) begin
         return COEF_TABLE[idx];
      end
      return '0;
   endfunction

endpackage

/* rtl/flp_if.sv */
// Valid/ready channel interfaces for filter samples and filtered results.
interface flp_req_if;
   import flp_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       block_start;

   modport source (output valid, output sample, output block_start, input ready);
   modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface flp_rsp_if;
   import flp_pkg::*;
   logic    valid;
   logic    ready;
   out_type filtered_value;

   modport source (output valid, output filtered_value, input ready);
   modport sink   (input valid, input filtered_value, output ready);
endinterface

/* rtl/flp_tap_cell.sv */
// One transposed-form tap: multiply the sample and add the partial sum from the next tap.
module flp_tap_cell (
   input  logic                clock,
   input  logic                reset,
   input  flp_pkg::ctl_type    ctl,
   input  flp_pkg::sample_type sample,
   input  flp_pkg::coef_type   coef,
   input  flp_pkg::acc_type    sum_in,
   output flp_pkg::acc_type    sum_out
);
   import flp_pkg::*;

   logic [PROD_W-1:0] product;
   acc_type           psum_ff;
   acc_type           psum_in;

   always_comb begin
      product = PROD_W'(sample) * PROD_W'(coef);
      // drop earlier history on block start
      psum_in = ACC_W'(product) + (ctl.clear ? ACC_W'(0) : sum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psum_ff <= '0;
      end else if (ctl.advance) begin
         psum_ff <= psum_in;
      end
   end

   assign sum_out = psum_ff;

endmodule

/* rtl/flp_out_stage.sv */
// Final tap, rounding, saturation and two-entry output buffer of the filter.
module flp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  flp_pkg::ctl_type    ctl,
   input  flp_pkg::sample_type sample,
   input  flp_pkg::acc_type    sum_in,
   output logic                ready,
   flp_rsp_if.source           rsp
);
   import flp_pkg::*;

   localparam coef_type COEF0 = tap_coef(0);

   logic [PROD_W-1:0] product;
   logic [SUM_W-1:0]  total;
   logic [RND_W-1:0]  rounded;
   out_type           result;

   logic    main_valid_ff;
   logic    main_valid_in;
   out_type main_data_ff;
   out_type main_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   out_type skid_data_ff;
   out_type skid_data_in;

   always_comb begin
      product = PROD_W'(sample) * PROD_W'(COEF0);
      total   = SUM_W'(product) + (ctl.clear ? SUM_W'(0) : SUM_W'(sum_in)) + ROUND_BIAS;
      rounded = total[SUM_W-1:ROUND_SHIFT];
      if (rounded > RND_W'(OUT_MAX)) begin
         result = OUT_MAX;
      end else begin
         result = rounded[OUT_W-1:0];
      end
   end

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      // advance the buffer on an output transfer
      if (main_valid_ff && rsp.ready) begin
         main_valid_in = skid_valid_ff;
         main_data_in  = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      // hold a new result in the skid entry when the main entry stays full
      if (ctl.advance) begin
         if (main_valid_in) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign ready              = ~skid_valid_ff;
   assign rsp.valid          = main_valid_ff;
   assign rsp.filtered_value = main_data_ff;

endmodule

/* rtl/fir_low_pass_32_tap_core.sv */
// Top level of the 32-tap low-pass FIR filter: transposed systolic tap chain and output stage.
// A result is registered into the main or skid output entry on its sample transfer.
// One sample per cycle while the skid entry is empty; the tap chain advances on each transfer.
// A two-entry output buffer keeps taking samples while one result waits to be taken.
// Reset clears every partial sum, so history before the first sample counts as zero.
module fir_low_pass_32_tap_core (
   input  logic      clock,
   input  logic      reset,
   flp_req_if.sink   req_bus,
   flp_rsp_if.source rsp_bus
);
   import flp_pkg::*;

   ctl_type ctl;
   logic    stage_ready;
   acc_type chain [1:TAPS];

   assign req_bus.ready = stage_ready;
   assign ctl.advance   = req_bus.valid & stage_ready;
   assign ctl.clear     = req_bus.block_start;
   assign chain[TAPS]   = '0;

   for (genvar k = 1; k < TAPS; k++) begin : g_tap
      flp_tap_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .sample  (req_bus.sample),
         .coef    (tap_coef(k)),
         .sum_in  (chain[k+1]),
         .sum_out (chain[k])
      );
   end

   flp_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_bus.sample),
      .sum_in (chain[1]),
      .ready  (stage_ready),
      .rsp    (rsp_bus)
   );

endmodule

/* dv/tb_fir_low_pass_32_tap_core.sv */
// Self-checking testbench for the 32-tap low-pass FIR filter core.
module tb_fir_low_pass_32_tap_core;
   timeunit 1ns;
   timeprecision 1ps;

   import flp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned PHASE_ITEMS = 200;
   localparam int unsigned FILTER_COEFS [32] = '{
      918,   1077,  1476,  2128,  3031,  4166,  5500,  6984,
      8560,  10160, 11711, 13141, 14381, 15369, 16057, 16410,
      16410, 16057, 15369, 14381, 13141, 11711, 10160, 8560,
      6984,  5500,  4166,  3031,  2128,  1476,  1077,  918
   };

   typedef enum int {
      STYLE_RANDOM,
      STYLE_FULL_SCALE,
      STYLE_SILENT,
      STYLE_QUIET,
      STYLE_TOGGLE
   } block_style_type;

   class lowpass_tracker;
      int unsigned     error_count;
      int unsigned     output_index;
      out_type         expected_outputs[$];
      sample_type      delay_line[TAPS-1];
      logic [TAPS-2:0] delay_live;

      function new();
         error_count  = 0;
         output_index = 0;
         delay_line   = '{default: '0};
         delay_live   = '0;
      endfunction

      function logic [63:0] coef_at(int j);
         if (j >= 0 && j < 32) begin
            return 64'(FILTER_COEFS[j]);
         end
         return 64'd0;
      endfunction

      function out_type filter_sample(sample_type x, logic start);
         logic [63:0] acc;
         logic [63:0] rounded;
         if (start) begin
            delay_live = '0;
         end
         acc = 64'(x) * coef_at(0);
         for (int k = 0; k < TAPS - 1; k++) begin
            if (delay_live[k]) begin
               acc += 64'(delay_line[k]) * coef_at(k + 1);
            end
         end
         rounded = (acc + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         for (int k = TAPS - 2; k > 0; k--) begin
            delay_line[k] = delay_line[k-1];
         end
         delay_line[0] = x;
         delay_live    = {delay_live[TAPS-3:0], 1'b1};
         return (rounded > 64'(OUT_MAX)) ? OUT_MAX : out_type'(rounded);
      endfunction

      function void note_sample(sample_type x, logic start);
         expected_outputs.push_back(filter_sample(x, start));
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns ERROR: %s", $realtime, msg);
         error_count++;
      endtask

      task check_output(out_type got);
         out_type want;
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("filtered_value %0d with no sample waiting", got));
         end else begin
            want = expected_outputs.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("output %0d: filtered_value %0d, want %0d",
                                         output_index, got, want));
            end
         end
         output_index++;
      endtask

      function int unsigned pending();
         return expected_outputs.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   lowpass_tracker tracker;

   flp_req_if req_bus ();
   flp_rsp_if rsp_bus ();

   fir_low_pass_32_tap_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // note accepted samples before checking results of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_sample(req_bus.sample, req_bus.block_start);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_output(rsp_bus.filtered_value);
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task send_sample(sample_type x, logic start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= x;
      req_bus.block_start <= start;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task wait_for_outputs();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task send_directed();
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      for (int i = 0; i < 10; i++) begin
         send_sample(16'hFFFF, 1'b0);
      end
      send_sample(16'h0000, 1'b1);
      send_sample(16'h0001, 1'b1);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h0000, 1'b0);
   endtask

   function sample_type pick_sample(block_style_type style, int unsigned pos);
      case (style)
         STYLE_FULL_SCALE: begin
            return 16'hFFFF;
         end
         STYLE_SILENT: begin
            return 16'h0000;
         end
         STYLE_QUIET: begin
            return sample_type'($urandom_range(255));
         end
         STYLE_TOGGLE: begin
            return pos[0] ? 16'h0000 : 16'hFFFF;
         end
         default: begin
            return sample_type'($urandom());
         end
      endcase
   endfunction

   // well-formed blocks with random content, plus stray block starts and unflagged runs
   task send_random_blocks(int unsigned target);
      int unsigned     sent;
      int unsigned     block_len;
      logic            flag_first;
      logic            start;
      block_style_type style;
      sent = 0;
      while (sent < target) begin
         block_len  = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 48);
         style      = block_style_type'($urandom_range(4));
         flag_first = ($urandom_range(9) != 0);
         for (int unsigned i = 0; i < block_len; i++) begin
            start = (i == 0) ? flag_first : ($urandom_range(49) == 0);
            send_sample(pick_sample(style, i), start);
            sent++;
         end
      end
   endtask

   initial begin
      tracker             = new();
      sender_idle_pct     = 0;
      receiver_idle_pct   = 0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.sample      = '0;
      req_bus.block_start = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct   = 19;
      receiver_idle_pct = 54;
      send_directed();
      send_random_blocks(PHASE_ITEMS);

      wait_for_outputs();
      sender_idle_pct   = 54;
      receiver_idle_pct = 19;
      send_random_blocks(PHASE_ITEMS);

      wait_for_outputs();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      send_random_blocks(PHASE_ITEMS);

      wait_for_outputs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
